// File: sv/bmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_pkg: shared types and constants of the box mesh generator
// Holds status codes, item kinds, register indexes, the job and result
// records and the corner table of the six-tetrahedra cell split.
// ----------------------------------------------------------------------------
package bmg_pkg;

    localparam logic [9:0] MAX_DIVISIONS = 10'd255;
    localparam int         DIV_STEPS     = 40;   // dividend width of a coordinate
    localparam int         NUM_TETS      = 6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADCFG = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_ERR  = 2'd0,
        K_NODE = 2'd1,
        K_CELL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_DIV_X  = 3'd0,
        REG_DIV_Y  = 3'd1,
        REG_DIV_Z  = 3'd2,
        REG_SIZE_X = 3'd3,
        REG_SIZE_Y = 3'd4,
        REG_SIZE_Z = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_DIV  = 2'd1,
        B_CELL = 2'd2
    } t_bstate;

    // One classified item as the front part hands it to the back part.
    typedef struct packed {
        t_kind         kind;
        t_status       status;
        logic [23:0]   base;       // linear id of the cell's corner 0
        logic [8:0]    stride_y;   // div_x + 1
        logic [16:0]   stride_z;   // (div_x + 1) * (div_y + 1)
        logic [39:0]   num_x;      // size * index, to be divided
        logic [39:0]   num_y;
        logic [39:0]   num_z;
        logic [7:0]    den_x;
        logic [7:0]    den_y;
        logic [7:0]    den_z;
    } t_job;

    typedef struct packed {
        t_status     status;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic [23:0] vertex_a;
        logic [23:0] vertex_b;
        logic [23:0] vertex_c;
        logic [23:0] vertex_d;
        logic        last;
    } t_result;

    // Corners of the six tetrahedra around the main diagonal of a cell.
    // Corner bit 0 is the x offset, bit 1 the y offset, bit 2 the z offset.
    localparam logic [2:0] KUHN_CORNERS [NUM_TETS][4] = '{
        '{3'd0, 3'd1, 3'd3, 3'd7},
        '{3'd0, 3'd3, 3'd2, 3'd7},
        '{3'd0, 3'd2, 3'd6, 3'd7},
        '{3'd0, 3'd6, 3'd4, 3'd7},
        '{3'd0, 3'd4, 3'd5, 3'd7},
        '{3'd0, 3'd5, 3'd1, 3'd7}
    };

    function automatic logic [23:0] corner_id(
        input logic [23:0] base,
        input logic [8:0]  sy,
        input logic [16:0] sz,
        input logic [2:0]  corner
    );
        logic [23:0] acc;
        acc = base;
        if (corner[0]) acc = acc + 24'd1;
        if (corner[1]) acc = acc + 24'(sy);
        if (corner[2]) acc = acc + 24'(sz);
        return acc;
    endfunction

endpackage

// File: sv/box_tetra_mesh_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_tetra_mesh_generator: structured tetrahedral mesh of a box
// Answers node requests with Q16.16 coordinates and cell requests with the
// six tetrahedra that share the cell's main diagonal.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  request   in         push / full        opcode, x/y/z index
//  result    out        empty / pop        status, coords, four vertices, last
//  config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// A cell request yields six items, one per cycle while the result buffer has
// room, after the back part loads the job from its idle state. The three
// coordinates of a node request are divided in parallel, one quotient bit
// per cycle over a 40-bit dividend. Error items are emitted straight from
// the back part's idle state. Reset is synchronous and active low; it
// empties all queues and returns the registers to a unit box of one cell.
// Either side may stall: a two-entry job queue and a two-entry result
// buffer keep intake and delivery independent.
module box_tetra_mesh_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_x_index,
    input  logic [7:0]  i_y_index,
    input  logic [7:0]  i_z_index,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_coord_x,
    output logic [31:0] o_coord_y,
    output logic [31:0] o_coord_z,
    output logic [23:0] o_vertex_a,
    output logic [23:0] o_vertex_b,
    output logic [23:0] o_vertex_c,
    output logic [23:0] o_vertex_d,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic [7:0]  r_div_x, r_div_y, r_div_z;
    logic [31:0] r_size_x, r_size_y, r_size_z;

    logic             job_valid, job_ready, q_valid, q_pop;
    bmg_pkg::t_job    job, q_job;
    bmg_pkg::t_result res;

    // Writes to unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_x  <= 8'd1;
            r_div_y  <= 8'd1;
            r_div_z  <= 8'd1;
            r_size_x <= 32'd65536;
            r_size_y <= 32'd65536;
            r_size_z <= 32'd65536;
        end else if (i_cfg_we) begin
            case (bmg_pkg::t_reg'(i_cfg_idx))
                bmg_pkg::REG_DIV_X:  r_div_x  <= i_cfg_data[7:0];
                bmg_pkg::REG_DIV_Y:  r_div_y  <= i_cfg_data[7:0];
                bmg_pkg::REG_DIV_Z:  r_div_z  <= i_cfg_data[7:0];
                bmg_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                bmg_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                bmg_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bmg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_x_index   (i_x_index),
        .i_y_index   (i_y_index),
        .i_z_index   (i_z_index),
        .i_div_x     (r_div_x),
        .i_div_y     (r_div_y),
        .i_div_z     (r_div_z),
        .i_size_x    (r_size_x),
        .i_size_y    (r_size_y),
        .i_size_z    (r_size_z),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    bmg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (job_valid),
        .o_wr_ready (job_ready),
        .i_wr_job   (job),
        .o_rd_valid (q_valid),
        .i_rd_pop   (q_pop),
        .o_rd_job   (q_job)
    );

    bmg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_job       (q_job),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (res)
    );

    assign o_status   = res.status;
    assign o_coord_x  = res.coord_x;
    assign o_coord_y  = res.coord_y;
    assign o_coord_z  = res.coord_z;
    assign o_vertex_a = res.vertex_a;
    assign o_vertex_b = res.vertex_b;
    assign o_vertex_c = res.vertex_c;
    assign o_vertex_d = res.vertex_d;
    assign o_last     = res.last;

endmodule

// File: sv/bmg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_front: item intake and classification
// Two stages: the first checks configuration and range and forms the
// products, the second forms the cell's base node id.
// ----------------------------------------------------------------------------
module bmg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_opcode,
    input  logic [7:0]       i_x_index,
    input  logic [7:0]       i_y_index,
    input  logic [7:0]       i_z_index,
    input  logic [7:0]       i_div_x,
    input  logic [7:0]       i_div_y,
    input  logic [7:0]       i_div_z,
    input  logic [31:0]      i_size_x,
    input  logic [31:0]      i_size_y,
    input  logic [31:0]      i_size_z,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output bmg_pkg::t_job    o_job
);

    logic              r_v1, r_v2;
    logic              r_op;
    logic [7:0]        r_i, r_j, r_k;
    logic              adv1, adv2;

    bmg_pkg::t_kind    kind1;
    bmg_pkg::t_status  status1;
    logic              cfg_bad, rng_bad;
    logic [16:0]       m1;
    logic [8:0]        sy1;
    logic [16:0]       sz1;

    bmg_pkg::t_kind    r_kind;
    bmg_pkg::t_status  r_status;
    logic [7:0]        r_i2;
    logic [16:0]       r_m1;
    logic [8:0]        r_sy;
    logic [16:0]       r_sz;
    logic [39:0]       r_px, r_py, r_pz;
    logic [7:0]        r_dx, r_dy, r_dz;
    logic [25:0]       base_full;

    assign adv2   = !r_v2 || i_job_ready;
    assign adv1   = !r_v1 || adv2;
    assign o_full = !adv1;

    always_comb begin
        cfg_bad = (i_div_x == 8'd0) || (i_div_y == 8'd0) || (i_div_z == 8'd0)
               || ({2'b00, i_div_x} > bmg_pkg::MAX_DIVISIONS)
               || ({2'b00, i_div_y} > bmg_pkg::MAX_DIVISIONS)
               || ({2'b00, i_div_z} > bmg_pkg::MAX_DIVISIONS)
               || (i_size_x == 32'd0) || (i_size_y == 32'd0) || (i_size_z == 32'd0);
        if (!r_op) begin
            rng_bad = (r_i > i_div_x) || (r_j > i_div_y) || (r_k > i_div_z);
        end else begin
            rng_bad = (r_i >= i_div_x) || (r_j >= i_div_y) || (r_k >= i_div_z);
        end
        if (cfg_bad) begin
            kind1   = bmg_pkg::K_ERR;
            status1 = bmg_pkg::ST_BADCFG;
        end else if (rng_bad) begin
            kind1   = bmg_pkg::K_ERR;
            status1 = bmg_pkg::ST_RANGE;
        end else if (r_op) begin
            kind1   = bmg_pkg::K_CELL;
            status1 = bmg_pkg::ST_OK;
        end else begin
            kind1   = bmg_pkg::K_NODE;
            status1 = bmg_pkg::ST_OK;
        end
        sy1 = {1'b0, i_div_x} + 9'd1;
        sz1 = 17'(sy1) * 17'({1'b0, i_div_y} + 9'd1);
        m1  = 17'({1'b0, i_div_y} + 9'd1) * 17'(r_k) + 17'(r_j);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_push;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_push) begin
            r_op <= i_opcode;
            r_i  <= i_x_index;
            r_j  <= i_y_index;
            r_k  <= i_z_index;
        end
        if (adv2 && r_v1) begin
            r_kind   <= kind1;
            r_status <= status1;
            r_i2     <= r_i;
            r_m1     <= m1;
            r_sy     <= sy1;
            r_sz     <= sz1;
            r_px     <= 40'(i_size_x) * 40'(r_i);
            r_py     <= 40'(i_size_y) * 40'(r_j);
            r_pz     <= 40'(i_size_z) * 40'(r_k);
            r_dx     <= i_div_x;
            r_dy     <= i_div_y;
            r_dz     <= i_div_z;
        end
    end

    assign base_full   = 26'(r_sy) * 26'(r_m1) + 26'(r_i2);
    assign o_job_valid = r_v2;

    always_comb begin
        o_job.kind     = r_kind;
        o_job.status   = r_status;
        o_job.base     = base_full[23:0];
        o_job.stride_y = r_sy;
        o_job.stride_z = r_sz;
        o_job.num_x    = r_px;
        o_job.num_y    = r_py;
        o_job.num_z    = r_pz;
        o_job.den_x    = r_dx;
        o_job.den_y    = r_dy;
        o_job.den_z    = r_dz;
    end

endmodule

// File: sv/bmg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_queue: two-entry job queue between front and back
// Decouples intake from result generation so each side stalls on its own.
// ----------------------------------------------------------------------------
module bmg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  bmg_pkg::t_job i_wr_job,
    output logic          o_rd_valid,
    input  logic          i_rd_pop,
    output bmg_pkg::t_job o_rd_job
);

    bmg_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          do_wr, do_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = i_rd_pop && o_rd_valid;
    assign o_rd_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_wr) r_wp <= !r_wp;
            if (do_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_wr_job;
    end

endmodule

// File: sv/bmg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_back: result generation
// Runs three bit-serial dividers for node coordinates, walks the six
// tetrahedra of a cell one a cycle while its two-entry result buffer has room.
// ----------------------------------------------------------------------------
module bmg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    input  bmg_pkg::t_job    i_job,
    output logic             o_empty,
    input  logic             i_pop,
    output bmg_pkg::t_result o_result
);

    bmg_pkg::t_bstate r_state, n_state;
    logic [2:0]       r_tet;
    logic [5:0]       r_cnt;
    logic [23:0]      r_base;
    logic [8:0]       r_sy;
    logic [16:0]      r_sz;
    logic [39:0]      r_num [3];
    logic [7:0]       r_rem [3];
    logic [7:0]       r_den [3];
    logic [39:0]      n_num [3];
    logic [7:0]       n_rem [3];

    bmg_pkg::t_result r_ob [2];
    logic             r_ob_wp, r_ob_rp;
    logic [1:0]       r_ob_cnt;
    logic             space, emit, do_pop, load, div_step, div_done;
    bmg_pkg::t_result emit_data;

    assign space    = (r_ob_cnt != 2'd2);
    assign div_done = (r_cnt == 6'(bmg_pkg::DIV_STEPS));
    assign div_step = (r_state == bmg_pkg::B_DIV) && !div_done;
    assign do_pop   = i_pop && !o_empty;
    assign o_empty  = (r_ob_cnt == 2'd0);
    assign o_result = r_ob[r_ob_rp];

    always_comb begin
        logic [8:0] trial;
        for (int a = 0; a < 3; a++) begin
            trial = {r_rem[a], r_num[a][39]};
            if (trial >= {1'b0, r_den[a]}) begin
                n_rem[a] = 8'(trial - {1'b0, r_den[a]});
                n_num[a] = {r_num[a][38:0], 1'b1};
            end else begin
                n_rem[a] = trial[7:0];
                n_num[a] = {r_num[a][38:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        emit      = 1'b0;
        o_job_pop = 1'b0;
        load      = 1'b0;
        emit_data = '0;
        emit_data.last = 1'b1;
        case (r_state)
            bmg_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        bmg_pkg::K_ERR: begin
                            if (space) begin
                                emit             = 1'b1;
                                o_job_pop        = 1'b1;
                                emit_data.status = i_job.status;
                            end
                        end
                        bmg_pkg::K_NODE: begin
                            o_job_pop = 1'b1;
                            load      = 1'b1;
                            n_state   = bmg_pkg::B_DIV;
                        end
                        bmg_pkg::K_CELL: begin
                            o_job_pop = 1'b1;
                            load      = 1'b1;
                            n_state   = bmg_pkg::B_CELL;
                        end
                        default: begin
                            o_job_pop = 1'b1;
                        end
                    endcase
                end
            end
            bmg_pkg::B_DIV: begin
                if (div_done && space) begin
                    emit              = 1'b1;
                    emit_data.status  = bmg_pkg::ST_OK;
                    emit_data.coord_x = r_num[0][31:0];
                    emit_data.coord_y = r_num[1][31:0];
                    emit_data.coord_z = r_num[2][31:0];
                    n_state           = bmg_pkg::B_IDLE;
                end
            end
            bmg_pkg::B_CELL: begin
                if (space) begin
                    emit               = 1'b1;
                    emit_data.status   = bmg_pkg::ST_OK;
                    emit_data.vertex_a = bmg_pkg::corner_id(r_base, r_sy, r_sz,
                                         bmg_pkg::KUHN_CORNERS[r_tet][0]);
                    emit_data.vertex_b = bmg_pkg::corner_id(r_base, r_sy, r_sz,
                                         bmg_pkg::KUHN_CORNERS[r_tet][1]);
                    emit_data.vertex_c = bmg_pkg::corner_id(r_base, r_sy, r_sz,
                                         bmg_pkg::KUHN_CORNERS[r_tet][2]);
                    emit_data.vertex_d = bmg_pkg::corner_id(r_base, r_sy, r_sz,
                                         bmg_pkg::KUHN_CORNERS[r_tet][3]);
                    emit_data.last     = (r_tet == 3'(bmg_pkg::NUM_TETS - 1));
                    if (emit_data.last) n_state = bmg_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = bmg_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmg_pkg::B_IDLE;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            if (emit)   r_ob_wp <= !r_ob_wp;
            if (do_pop) r_ob_rp <= !r_ob_rp;
            r_ob_cnt <= r_ob_cnt + 2'(emit) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_ob[r_ob_wp] <= emit_data;
        if (load) begin
            r_tet    <= 3'd0;
            r_cnt    <= 6'd0;
            r_base   <= i_job.base;
            r_sy     <= i_job.stride_y;
            r_sz     <= i_job.stride_z;
            r_num[0] <= i_job.num_x;
            r_num[1] <= i_job.num_y;
            r_num[2] <= i_job.num_z;
            r_den[0] <= i_job.den_x;
            r_den[1] <= i_job.den_y;
            r_den[2] <= i_job.den_z;
            r_rem[0] <= 8'd0;
            r_rem[1] <= 8'd0;
            r_rem[2] <= 8'd0;
        end else begin
            if (div_step) begin
                r_cnt <= r_cnt + 6'd1;
                for (int a = 0; a < 3; a++) begin
                    r_num[a] <= n_num[a];
                    r_rem[a] <= n_rem[a];
                end
            end
            if (r_state == bmg_pkg::B_CELL && emit) r_tet <= r_tet + 3'd1;
        end
    end

endmodule

// File: sv/bmg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_checker: port-level checks of the box mesh generator
// Watches the result side only and is bound to the top level.
// ----------------------------------------------------------------------------
module bmg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [31:0] o_coord_x,
    input logic [23:0] o_vertex_a,
    input logic        o_last
);

    // Reset drops every buffered item.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status != 2'd3))
        else $error("undefined status code");

    // Errors always stand alone as the final item of their request.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != 2'd0) |-> o_last)
        else $error("error item not marked last");

    // A node item is a single item, hence last.
    a_coord_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_coord_x != 32'd0) |-> o_last)
        else $error("coordinate item not marked last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_vertex_a) && $stable(o_last)))
        else $error("waiting item changed");

endmodule

bind box_tetra_mesh_generator bmg_checker u_bmg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_status   (o_status),
    .o_coord_x  (o_coord_x),
    .o_vertex_a (o_vertex_a),
    .o_last     (o_last)
);

// File: sim/box_tetra_mesh_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_tetra_mesh_generator_tb: self-checking bench of the box mesh generator
// Feeds node and cell requests over the push/full port in random bursts,
// pops results with a stalling receiver and compares every field against a
// mesh predictor that tracks the register settings of each phase.
// ----------------------------------------------------------------------------
module box_tetra_mesh_generator_tb;

    typedef struct packed {
        logic       opcode;
        logic [7:0] xi;
        logic [7:0] yi;
        logic [7:0] zi;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_x_index = '0, i_y_index = '0, i_z_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_coord_x, o_coord_y, o_coord_z;
    logic [23:0] o_vertex_a, o_vertex_b, o_vertex_c, o_vertex_d;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    box_tetra_mesh_generator uut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers.
    logic [7:0]  m_div [3];
    logic [31:0] m_size [3];

    t_req             pending_reqs [$];
    bmg_pkg::t_result expected_results [$];
    int               fail_count = 0;
    int               burst_left = 0;
    int               gap_left = 0;
    bit               drv_go;

    task automatic queue_req(input t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic expect_item(input bmg_pkg::t_result r);
        expected_results = {expected_results, r};
    endtask

    function automatic logic [23:0] node_lin(input logic [8:0] i, input logic [8:0] j,
                                             input logic [8:0] k);
        logic [63:0] v;
        v = 64'(i) + (64'(m_div[0]) + 1) * (64'(j) + (64'(m_div[1]) + 1) * 64'(k));
        return v[23:0];
    endfunction

    function automatic logic [31:0] scale_coord(input logic [31:0] sz, input logic [7:0] idx,
                                                input logic [7:0] d);
        logic [63:0] p;
        p = (64'(sz) * 64'(idx)) / 64'(d);
        return p[31:0];
    endfunction

    // Works out the results of one request under the current settings.
    task automatic predict_mesh(input t_req r);
        bmg_pkg::t_result res;
        logic [2:0] c;
        logic [23:0] vtx [4];
        res = '0;
        res.last = 1'b1;
        if (m_div[0] == 0 || m_div[1] == 0 || m_div[2] == 0 ||
            m_size[0] == 0 || m_size[1] == 0 || m_size[2] == 0) begin
            res.status = bmg_pkg::ST_BADCFG;
            expect_item(res);
        end else if (r.opcode == 1'b0) begin
            if (r.xi > m_div[0] || r.yi > m_div[1] || r.zi > m_div[2]) begin
                res.status = bmg_pkg::ST_RANGE;
            end else begin
                res.status = bmg_pkg::ST_OK;
                res.coord_x = scale_coord(m_size[0], r.xi, m_div[0]);
                res.coord_y = scale_coord(m_size[1], r.yi, m_div[1]);
                res.coord_z = scale_coord(m_size[2], r.zi, m_div[2]);
            end
            expect_item(res);
        end else if (r.xi >= m_div[0] || r.yi >= m_div[1] || r.zi >= m_div[2]) begin
            res.status = bmg_pkg::ST_RANGE;
            expect_item(res);
        end else begin
            // Six tetrahedra sharing the diagonal from corner 0 to corner 7.
            for (int t = 0; t < bmg_pkg::NUM_TETS; t++) begin
                for (int v = 0; v < 4; v++) begin
                    c = bmg_pkg::KUHN_CORNERS[t][v];
                    vtx[v] = node_lin(9'(r.xi) + 9'(c[0]), 9'(r.yi) + 9'(c[1]),
                                      9'(r.zi) + 9'(c[2]));
                end
                res = '0;
                res.status = bmg_pkg::ST_OK;
                res.vertex_a = vtx[0];
                res.vertex_b = vtx[1];
                res.vertex_c = vtx[2];
                res.vertex_d = vtx[3];
                res.last = (t == bmg_pkg::NUM_TETS - 1);
                expect_item(res);
            end
        end
    endtask

    // Driver: bursts of pushes separated by random gaps. Prediction happens
    // at acceptance, so register writes between phases are seen in order.
    // The item on the ports is always the head of the pending queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_mesh(pending_reqs.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                drv_go = 1'b1;
                if (push && !full) begin
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(12, 1);
                        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
                        drv_go = ($urandom_range(1) == 0);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                // A waiting item keeps its fields until it is taken.
                if (!(push && full)) begin
                    i_opcode <= pending_reqs[0].opcode;
                    i_x_index <= pending_reqs[0].xi;
                    i_y_index <= pending_reqs[0].yi;
                    i_z_index <= pending_reqs[0].zi;
                end
                push <= drv_go;
            end else if (!(push && full)) begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks the popped item and stalls on its own pattern.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    bmg_pkg::t_result e;
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_status);
                        fail_count++;
                    end
                    if (o_coord_x !== e.coord_x) begin
                        $error("coord_x expected %0h actual %0h", e.coord_x, o_coord_x);
                        fail_count++;
                    end
                    if (o_coord_y !== e.coord_y) begin
                        $error("coord_y expected %0h actual %0h", e.coord_y, o_coord_y);
                        fail_count++;
                    end
                    if (o_coord_z !== e.coord_z) begin
                        $error("coord_z expected %0h actual %0h", e.coord_z, o_coord_z);
                        fail_count++;
                    end
                    if (o_vertex_a !== e.vertex_a) begin
                        $error("vertex_a expected %0d actual %0d", e.vertex_a, o_vertex_a);
                        fail_count++;
                    end
                    if (o_vertex_b !== e.vertex_b) begin
                        $error("vertex_b expected %0d actual %0d", e.vertex_b, o_vertex_b);
                        fail_count++;
                    end
                    if (o_vertex_c !== e.vertex_c) begin
                        $error("vertex_c expected %0d actual %0d", e.vertex_c, o_vertex_c);
                        fail_count++;
                    end
                    if (o_vertex_d !== e.vertex_d) begin
                        $error("vertex_d expected %0d actual %0d", e.vertex_d, o_vertex_d);
                        fail_count++;
                    end
                    if (o_last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, o_last);
                        fail_count++;
                    end
                end
            end
            // Stall pattern: long free stretches, then dense random stalls.
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30) pop <= 1'b1;
            else if (stall_phase < 60) pop <= ($urandom_range(3) != 0);
            else pop <= ($urandom_range(2) == 0);
        end
    end

    task automatic write_reg(input bmg_pkg::t_reg idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= bmg_pkg::REG_DIV_Z) m_div[idx] = val[7:0];
        else m_size[idx - bmg_pkg::REG_SIZE_X] = val;
    endtask

    task automatic set_mesh(input logic [7:0] dx, input logic [7:0] dy, input logic [7:0] dz,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sz);
        write_reg(bmg_pkg::REG_DIV_X, 32'(dx));
        write_reg(bmg_pkg::REG_DIV_Y, 32'(dy));
        write_reg(bmg_pkg::REG_DIV_Z, 32'(dz));
        write_reg(bmg_pkg::REG_SIZE_X, sx);
        write_reg(bmg_pkg::REG_SIZE_Y, sy);
        write_reg(bmg_pkg::REG_SIZE_Z, sz);
    endtask

    // Waits until the block has drained, plus the longest node latency.
    task automatic drain;
        while (pending_reqs.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_req req_of(input logic op, input logic [7:0] x, input logic [7:0] y,
                                    input logic [7:0] z);
        t_req r;
        r.opcode = op; r.xi = x; r.yi = y; r.zi = z;
        return r;
    endfunction

    // Random request: mostly in range for the current settings.
    function automatic t_req rand_req;
        t_req r;
        r.opcode = 1'($urandom_range(1));
        if ($urandom_range(7) == 0) begin
            r.xi = 8'($urandom); r.yi = 8'($urandom); r.zi = 8'($urandom);
        end else begin
            r.xi = 8'($urandom_range(32'(m_div[0]) - 32'(r.opcode)));
            r.yi = 8'($urandom_range(32'(m_div[1]) - 32'(r.opcode)));
            r.zi = 8'($urandom_range(32'(m_div[2]) - 32'(r.opcode)));
        end
        return r;
    endfunction

    task automatic random_phase(input int n);
        for (int q = 0; q < n; q++) queue_req(rand_req());
        drain();
    endtask

    initial begin
        m_div = '{8'd1, 8'd1, 8'd1};
        m_size = '{32'd65536, 32'd65536, 32'd65536};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset unit box, corners, and out-of-range items.
        queue_req(req_of(1'b0, 8'd0, 8'd0, 8'd0));
        queue_req(req_of(1'b0, 8'd1, 8'd1, 8'd1));
        queue_req(req_of(1'b1, 8'd0, 8'd0, 8'd0));
        queue_req(req_of(1'b1, 8'd1, 8'd0, 8'd0));
        queue_req(req_of(1'b0, 8'd2, 8'd0, 8'd0));
        queue_req(req_of(1'b0, 8'd255, 8'd255, 8'd255));
        drain();

        // Largest grid and full-scale sizes.
        set_mesh(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(req_of(1'b0, 8'd255, 8'd255, 8'd255));
        queue_req(req_of(1'b0, 8'd254, 8'd1, 8'd128));
        queue_req(req_of(1'b1, 8'd254, 8'd254, 8'd254));
        queue_req(req_of(1'b1, 8'd255, 8'd0, 8'd0));
        queue_req(req_of(1'b1, 8'd0, 8'd0, 8'd255));
        drain();

        // Invalid settings: zero division, then zero size.
        set_mesh(8'd0, 8'd3, 8'd3, 32'd1, 32'd1, 32'd1);
        queue_req(req_of(1'b0, 8'd0, 8'd0, 8'd0));
        queue_req(req_of(1'b1, 8'd0, 8'd0, 8'd0));
        drain();
        set_mesh(8'd3, 8'd3, 8'd3, 32'd1, 32'd0, 32'd1);
        queue_req(req_of(1'b1, 8'd1, 8'd1, 8'd1));
        drain();

        // Random phases over a few settings; each drain waits until every
        // expected result has come before the next settings are written.
        set_mesh(8'd7, 8'd3, 8'd5, 32'h0003_8000, 32'd1, 32'h1234_5678);
        random_phase(28);
        set_mesh(8'd2, 8'd200, 8'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0001);
        random_phase(28);
        set_mesh(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                 8'($urandom_range(255, 1)), $urandom, $urandom, $urandom);
        random_phase(30);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
